>>> hw/rtl/dht_pkg.sv
// Package for the double-hashing key/value table engine.
// Holds the item types, action and status codes, and default sizes.
// No dependencies.
package dht_pkg;

   localparam int SLOTS_DEF      = 31;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_REMOVED   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_value;
      logic [4:0]  live_count;
   } rsp_type;

endpackage

>>> hw/rtl/dht_hash.sv
// Remainder unit that turns a key into its first slot and its probe stride.
// Takes the key one byte per cycle, most significant byte first, and reduces each partial
// remainder with a constant reciprocal multiply. Depends on dht_pkg for default sizes.
module dht_hash #(
   parameter int SLOTS    = dht_pkg::SLOTS_DEF,
   parameter int KEY_BITS = dht_pkg::KEY_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_BITS-1:0]        key,
   output logic                       done,
   output logic [$clog2(SLOTS)-1:0]   start_pos,
   output logic [$clog2(SLOTS)-1:0]   stride
);

   localparam int PW  = $clog2(SLOTS);
   localparam int CB  = 8;
   localparam int NCH = (KEY_BITS + CB - 1) / CB;
   localparam int SW  = NCH * CB;
   localparam int NW  = $clog2(NCH + 1);
   localparam int AW  = PW + CB;
   localparam int MW  = AW + 2;
   localparam int SH  = AW + PW;
   localparam int PRW = AW + MW;
   localparam logic [AW-1:0]  DIV_A   = AW'(SLOTS);
   localparam logic [AW-1:0]  DIV_B   = AW'(SLOTS - 1);
   localparam logic [PRW-1:0] RCP_A   = PRW'(((64'd1 << SH) + SLOTS - 1) / SLOTS);
   localparam logic [PRW-1:0] RCP_B   = PRW'(((64'd1 << SH) + SLOTS - 2) / (SLOTS - 1));
   localparam logic [NW-1:0]  LAST_CH = NW'(NCH - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic [SW-1:0]       sh_ff, sh_in;
   logic [PW-1:0]       rem_a_ff, rem_a_in;
   logic [PW-1:0]       rem_b_ff, rem_b_in;
   logic [CB-1:0]       chunk_b;
   logic [AW-1:0]       acc_a;
   logic [AW-1:0]       acc_b;
   logic [PRW-1:0]      prod_a;
   logic [PRW-1:0]      prod_b;
   logic [AW-1:0]       quo_a;
   logic [AW-1:0]       quo_b;
   logic [AW-1:0]       res_a;
   logic [AW-1:0]       res_b;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      sh_in    = sh_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      chunk_b  = sh_ff[SW-1 -: CB] ^ {{(CB-1){1'b0}}, (cnt_ff == '0)};
      acc_a    = {rem_a_ff, sh_ff[SW-1 -: CB]};
      acc_b    = {rem_b_ff, chunk_b};
      prod_a   = PRW'(acc_a) * RCP_A;
      prod_b   = PRW'(acc_b) * RCP_B;
      quo_a    = AW'(prod_a >> SH);
      quo_b    = AW'(prod_b >> SH);
      res_a    = acc_a - quo_a * DIV_A;
      res_b    = acc_b - quo_b * DIV_B;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = LAST_CH;
         sh_in    = SW'(key);
         rem_a_in = '0;
         rem_b_in = '0;
      end else if (busy_ff) begin
         rem_a_in = res_a[PW-1:0];
         rem_b_in = res_b[PW-1:0];
         sh_in    = sh_ff << CB;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      sh_ff    <= sh_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
   end

   assign done      = done_ff;
   assign start_pos = rem_a_ff;
   assign stride    = rem_b_ff + 1'b1;

endmodule

>>> hw/rtl/double_hash_table_engine.sv
// Top level of the double-hashing key/value table engine with its slot memories.
// Depends on dht_pkg and dht_hash.
//
//   channel | ports                          | direction | payload
//   request | req_valid, req_stall, req_data | in        | dht_pkg::req_type
//   result  | rsp_valid, rsp_stall, rsp_data | out       | dht_pkg::rsp_type
//
// A result is registered after its item passes these states: the remainder unit takes
// the key one byte per cycle, then each slot probed (1 to SLOTS of them) has a read state
// and a compare state, and then come the commit state and the done state.
// An item with the unused action code skips the remainder unit and the probing states.
// After reset a clearing pass over all SLOTS slots empties the slot flags; req_stall is high.
// A finished result waits in the output register while rsp_stall is high, and the next
// item is accepted meanwhile; its own result waits until that register is free.
module double_hash_table_engine #(
   parameter int SLOTS      = dht_pkg::SLOTS_DEF,
   parameter int KEY_BITS   = dht_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = dht_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dht_pkg::rsp_type rsp_data
);

   localparam int PW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [PW:0]   SLOTS_W   = (PW+1)'(SLOTS);
   localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);
   localparam int OCC  = 0;
   localparam int TOMB = 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_CHECK,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [PW-1:0]         clr_ff, clr_in;
   logic [1:0]            act_ff, act_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         stride_ff, stride_in;
   logic [PW-1:0]         probe_ff, probe_in;
   logic [PW-1:0]         free_ff, free_in;
   logic                  free_vld_ff, free_vld_in;
   logic                  hit_ff, hit_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dht_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic [2:0]            status_ff, status_in;
   logic [31:0]           fval_ff, fval_in;

   logic [KEY_BITS-1:0]   key_mem [SLOTS];
   logic [VALUE_BITS-1:0] val_mem [SLOTS];
   logic [1:0]            flag_mem [SLOTS];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [1:0]            flag_rd_ff;

   logic                  key_we;
   logic                  val_we;
   logic                  flag_we;
   logic [PW-1:0]         wr_addr;
   logic [1:0]            flag_wr;

   logic                  hash_start;
   logic                  hash_done;
   logic [PW-1:0]         hash_pos;
   logic [PW-1:0]         hash_stride;
   logic                  accept;
   logic                  match;
   logic                  last_probe;
   logic [PW:0]           pos_sum;
   logic [PW-1:0]         pos_next;

   dht_hash #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .key       (KEY_BITS'(req_data.key)),
      .done      (hash_done),
      .start_pos (hash_pos),
      .stride    (hash_stride)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign hash_start = accept && ((req_data.action == dht_pkg::ACT_INSERT) ||
                                  (req_data.action == dht_pkg::ACT_SEARCH) ||
                                  (req_data.action == dht_pkg::ACT_REMOVE));
   assign match      = flag_rd_ff[OCC] && !flag_rd_ff[TOMB] && (key_rd_ff == key_ff);
   assign last_probe = (probe_ff == LAST_SLOT);

   always_comb begin
      pos_sum = {1'b0, pos_ff} + {1'b0, stride_ff};
      if (pos_sum >= SLOTS_W) begin
         pos_sum = pos_sum - SLOTS_W;
      end
      pos_next = pos_sum[PW-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      stride_in    = stride_ff;
      probe_in     = probe_ff;
      free_in      = free_ff;
      free_vld_in  = free_vld_ff;
      hit_in       = hit_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      fval_in      = fval_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      key_we       = 1'b0;
      val_we       = 1'b0;
      flag_we      = 1'b0;
      wr_addr      = pos_ff;
      flag_wr      = 2'b00;

      case (state_ff)
         S_CLEAR: begin
            flag_we = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in      = req_data.action;
               key_in      = KEY_BITS'(req_data.key);
               val_in      = VALUE_BITS'(req_data.value);
               probe_in    = '0;
               free_vld_in = 1'b0;
               hit_in      = 1'b0;
               state_in    = hash_start ? S_HASH : S_COMMIT;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               pos_in    = hash_pos;
               stride_in = hash_stride;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!flag_rd_ff[OCC]) begin
               if (!free_vld_ff) begin
                  free_in     = pos_ff;
                  free_vld_in = 1'b1;
               end
               state_in = S_COMMIT;
            end else if (match) begin
               hit_in   = 1'b1;
               state_in = S_COMMIT;
            end else begin
               if (flag_rd_ff[TOMB] && !free_vld_ff) begin
                  free_in     = pos_ff;
                  free_vld_in = 1'b1;
               end
               if (last_probe) begin
                  state_in = S_COMMIT;
               end else begin
                  pos_in   = pos_next;
                  probe_in = probe_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_COMMIT: begin
            fval_in   = '0;
            status_in = dht_pkg::ST_NOT_FOUND;
            state_in  = S_DONE;
            case (act_ff)
               dht_pkg::ACT_INSERT: begin
                  if (hit_ff) begin
                     val_we    = 1'b1;
                     status_in = dht_pkg::ST_UPDATED;
                  end else if (free_vld_ff) begin
                     wr_addr   = free_ff;
                     key_we    = 1'b1;
                     val_we    = 1'b1;
                     flag_we   = 1'b1;
                     flag_wr   = 2'b01;
                     count_in  = count_ff + 1'b1;
                     status_in = dht_pkg::ST_INSERTED;
                  end else begin
                     status_in = dht_pkg::ST_FULL;
                  end
               end
               dht_pkg::ACT_SEARCH: begin
                  if (hit_ff) begin
                     fval_in   = 32'(val_rd_ff);
                     status_in = dht_pkg::ST_FOUND;
                  end
               end
               dht_pkg::ACT_REMOVE: begin
                  if (hit_ff) begin
                     flag_we   = 1'b1;
                     flag_wr   = 2'b11;
                     status_in = dht_pkg::ST_REMOVED;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
               default: begin
                  status_in = dht_pkg::ST_NOT_FOUND;
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.found_value = fval_ff;
               rsp_data_in.live_count  = 5'(count_ff);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      stride_ff   <= stride_in;
      probe_ff    <= probe_in;
      free_ff     <= free_in;
      free_vld_ff <= free_vld_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      fval_ff     <= fval_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (val_we) begin
         val_mem[wr_addr] <= val_ff;
      end
      if (flag_we) begin
         flag_mem[wr_addr] <= flag_wr;
      end
      key_rd_ff  <= key_mem[pos_ff];
      val_rd_ff  <= val_mem[pos_ff];
      flag_rd_ff <= flag_mem[pos_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/dht_checker.sv
// Port-level checks for the double-hashing key/value table engine, bound to its top level.
// Depends on dht_pkg and double_hash_table_engine.
module dht_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dht_pkg::rsp_type rsp_data
);

   // A result that is held back stays unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while busy");

   // The clearing pass keeps the request side stalled after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open during clearing pass");

   // Only a found result carries a value.
   a_value_only_on_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != dht_pkg::ST_FOUND) |-> rsp_data.found_value == '0)
      else $error("value on a result other than found");

endmodule

bind double_hash_table_engine dht_checker u_dht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/dht_tb_pkg.sv
// Scoreboard for the double-hashing key/value table engine testbench.
// Predicts each result from the request items and checks the engine's results.
// Depends on dht_pkg.
`timescale 1ns / 1ps
package dht_tb_pkg;
   import dht_pkg::*;

   localparam int unsigned TABLE_SLOTS = dht_pkg::SLOTS_DEF;
   localparam logic [1:0]  ACT_UNUSED  = 2'd3;

   class table_scoreboard;
      logic [31:0] slot_key [TABLE_SLOTS];
      logic [31:0] slot_value [TABLE_SLOTS];
      bit          slot_used [TABLE_SLOTS];
      bit          slot_dead [TABLE_SLOTS];
      int unsigned live_entries;
      rsp_type     expected_rsp [$];
      int unsigned error_count;

      function new();
         live_entries = 0;
         error_count = 0;
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_dead[i] = 1'b0;
         end
      endfunction

      function void probe_params(input logic [31:0] k, output int unsigned pos,
                                 output int unsigned stride);
         pos = k % TABLE_SLOTS;
         stride = ((k ^ 32'd1) % (TABLE_SLOTS - 1)) + 1;
      endfunction

      function int locate_live(input logic [31:0] k);
         int unsigned pos;
         int unsigned stride;
         probe_params(k, pos, stride);
         repeat (TABLE_SLOTS) begin
            if (!slot_used[pos])
               return -1;
            if (!slot_dead[pos] && slot_key[pos] == k)
               return pos;
            pos = (pos + stride) % TABLE_SLOTS;
         end
         return -1;
      endfunction

      function void note_request(input req_type r);
         rsp_type     e;
         int          hit;
         int          free_slot;
         int unsigned pos;
         int unsigned stride;
         int unsigned n;
         e.status = ST_NOT_FOUND;
         e.found_value = '0;
         case (r.action)
            ACT_INSERT: begin
               hit = -1;
               free_slot = -1;
               probe_params(r.key, pos, stride);
               for (n = 0; n < TABLE_SLOTS; n++) begin
                  if (!slot_used[pos]) begin
                     if (free_slot < 0)
                        free_slot = pos;
                     break;
                  end
                  if (slot_dead[pos]) begin
                     if (free_slot < 0)
                        free_slot = pos;
                  end else if (slot_key[pos] == r.key) begin
                     hit = pos;
                     break;
                  end
                  pos = (pos + stride) % TABLE_SLOTS;
               end
               if (hit >= 0) begin
                  slot_value[hit] = r.value;
                  e.status = ST_UPDATED;
               end else if (free_slot >= 0) begin
                  slot_key[free_slot] = r.key;
                  slot_value[free_slot] = r.value;
                  slot_used[free_slot] = 1'b1;
                  slot_dead[free_slot] = 1'b0;
                  live_entries++;
                  e.status = ST_INSERTED;
               end else begin
                  e.status = ST_FULL;
               end
            end
            ACT_SEARCH: begin
               hit = locate_live(r.key);
               if (hit >= 0) begin
                  e.status = ST_FOUND;
                  e.found_value = slot_value[hit];
               end
            end
            ACT_REMOVE: begin
               hit = locate_live(r.key);
               if (hit >= 0) begin
                  slot_dead[hit] = 1'b1;
                  if (live_entries > 0)
                     live_entries--;
                  e.status = ST_REMOVED;
               end
            end
            default: ;
         endcase
         e.live_count = live_entries[4:0];
         expected_rsp.push_back(e);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result item: status %0d value %h count %0d",
                     $time, got.status, got.found_value, got.live_count);
            error_count++;
            return;
         end
         e = expected_rsp.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, e.status, got.status);
            error_count++;
         end
         if (got.found_value !== e.found_value) begin
            $display("%0t: found_value mismatch: expected %h actual %h",
                     $time, e.found_value, got.found_value);
            error_count++;
         end
         if (got.live_count !== e.live_count) begin
            $display("%0t: live_count mismatch: expected %0d actual %0d",
                     $time, e.live_count, got.live_count);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction
   endclass

endpackage

>>> tb/sv/tb_top.sv
// Top level of the testbench for the double-hashing key/value table engine.
// Drives directed and random request items and checks every result item.
// Depends on dht_pkg, dht_tb_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_top;
   import dht_pkg::*;
   import dht_tb_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SEGMENTS       = 10;
   localparam int unsigned SEGMENT_ITEMS  = 64;
   localparam int unsigned POOL_SIZE      = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   table_scoreboard sb;
   bit              no_idle = 1'b0;
   int unsigned     idle_cycles = 0;
   logic [31:0]     key_pool [POOL_SIZE];

   double_hash_table_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 9);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
         if (req_valid && !req_stall)
            sb.note_request(req_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] act, input logic [31:0] k,
                            input logic [31:0] v);
      req_type item;
      item.action = act;
      item.key = k;
      item.value = v;
      while (!no_idle && ($urandom_range(99) < 9)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_segment(input int unsigned w_ins, input int unsigned w_srch,
                                      input int unsigned w_rem);
      int unsigned r;
      logic [1:0]  act;
      logic [31:0] k;
      logic [31:0] v;
      repeat (SEGMENT_ITEMS) begin
         r = $urandom_range(99);
         if (r < w_ins)
            act = ACT_INSERT;
         else if (r < w_ins + w_srch)
            act = ACT_SEARCH;
         else if (r < w_ins + w_srch + w_rem)
            act = ACT_REMOVE;
         else
            act = ACT_UNUSED;
         if ($urandom_range(99) < 5)
            k = $urandom();
         else
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
         if ($urandom_range(9) == 0)
            v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         else
            v = $urandom();
         send_item(act, k, v);
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 12)
            key_pool[i] = 31 * $urandom_range(1000);
         else if (i < 24)
            key_pool[i] = $urandom();
         else if (i < 30)
            key_pool[i] = 32'hFFFF_FFFF - $urandom_range(40);
         else
            key_pool[i] = $urandom_range(62);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(ACT_SEARCH, 32'h0, 32'h0);
      send_item(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_item(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h0);
      send_item(ACT_INSERT, 32'h0, 32'h1234_5678);
      send_item(ACT_SEARCH, 32'h0, 32'hFFFF_FFFF);
      send_item(ACT_SEARCH, 32'hFFFF_FFFF, 32'h0);
      send_item(ACT_INSERT, 32'd31, 32'hA5A5_A5A5);
      send_item(ACT_REMOVE, 32'h0, 32'h0);
      send_item(ACT_SEARCH, 32'd31, 32'h0);
      send_item(ACT_INSERT, 32'd31, 32'h5A5A_5A5A);
      send_item(ACT_INSERT, 32'd62, 32'hFFFF_0000);
      send_item(ACT_REMOVE, 32'h0, 32'h0);
      send_item(ACT_SEARCH, 32'd62, 32'h0);
      send_item(ACT_REMOVE, 32'd31, 32'h0);
      send_item(ACT_REMOVE, 32'd62, 32'h0);
      send_item(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_item(ACT_SEARCH, 32'd31, 32'h0);

      for (int s = 0; s < SEGMENTS; s++) begin
         no_idle = (s == 4);
         for (int j = 0; j < 3; j++)
            key_pool[12 + $urandom_range(11)] = $urandom();
         case (s % 3)
            0: send_random_segment(70, 15, 10);
            1: send_random_segment(20, 25, 50);
            default: send_random_segment(40, 30, 25);
         endcase
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
      if (sb.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
